// ----- rtl/sbac_pkg.sv -----
// shared types and constants for the slot and byte admission controller
package sbac_pkg;

  localparam int unsigned SlotW    = 16;
  localparam int unsigned ByteW    = 48;
  localparam int unsigned SizeW    = 40;
  localparam int unsigned GenW     = 32;
  localparam int unsigned ChargeW  = 44;
  localparam int unsigned CountW   = 32;
  localparam int unsigned InDataW  = 128;
  localparam int unsigned OutDataW = 240;

  // fixed part of the charge: 16 MiB
  localparam logic [ChargeW-1:0] FixedCharge = ChargeW'(24'hFF_FFFF) + ChargeW'(1);

  localparam logic [SlotW-1:0] SlotLimitReset = SlotW'(16);
  localparam logic [ByteW-1:0] ByteCapReset   = '0;

  typedef enum logic [1:0] {
    KIND_RESERVE  = 2'd0,
    KIND_PREPARED = 2'd1,
    KIND_RELEASE  = 2'd2,
    KIND_CLOSE    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_CLOSING   = 3'd2,
    ST_SLOTS     = 3'd3,
    ST_BUDGET    = 3'd4,
    ST_UNDERFLOW = 3'd5
  } status_t;

  typedef enum logic {
    REG_SLOT_LIMIT = 1'b0,
    REG_BYTE_CAP   = 1'b1
  } reg_index_t;

  // first member sits in the highest bits, so status lands at bit 0
  typedef struct packed {
    logic              is_closing;
    logic [CountW-1:0] budget_rejects;
    logic [CountW-1:0] slot_rejects;
    logic [ByteW-1:0]  byte_peak;
    logic [SlotW-1:0]  slot_peak;
    logic [ByteW-1:0]  active_byte_total;
    logic [SlotW-1:0]  active_slots;
    logic [ChargeW-1:0] charged_bytes;
    status_t           status;
  } result_t;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    sat_inc = (v == '1) ? v : v + CountW'(1);
  endfunction

endpackage

// ----- rtl/slot_and_byte_admission_control.sv -----
// admission controller with a slot limit and a byte budget
//
// Items arrive on the s_ channel: tuser carries the kind (reserve, mark
// prepared, release, close) and tdata the request fields. Every accepted
// item yields exactly one result item on the m_ channel with a status and
// a snapshot of the counters after the item.
// Each result is registered in the result register, or in the skid register
// while one waits; one item is taken in every cycle while s_tready is high,
// set by the single add/compare stage between state and result registers.
// The result register is backed by a one-entry skid register, so an item
// is still taken while a result waits; s_tready drops only while the skid
// register is full, and clears again once the receiver takes a result.
// The configuration port writes slot_limit (index 0) or the byte cap
// (index 1), and is meant to be used while the block is idle.
// Synchronous reset clears all counters, marks and the closing flag, sets
// slot_limit to 16 and the byte cap to 0, and empties the output stages.
module slot_and_byte_admission_control (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [sbac_pkg::ByteW-1:0]    cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // content_bytes[39:0], generation[71:40], release_bytes[119:72],
  // holds_slot[120], zero padding above
  input  logic [sbac_pkg::InDataW-1:0]  s_tdata,
  // kind[1:0]
  input  logic [1:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // status[2:0], charged_bytes[46:3], active_slots[62:47],
  // active_byte_total[110:63], slot_peak[126:111], byte_peak[174:127],
  // slot_rejects[206:175], budget_rejects[238:207], is_closing[239]
  output logic [sbac_pkg::OutDataW-1:0] m_tdata
);

  localparam int unsigned SlotW   = sbac_pkg::SlotW;
  localparam int unsigned ByteW   = sbac_pkg::ByteW;
  localparam int unsigned ChargeW = sbac_pkg::ChargeW;
  localparam int unsigned CountW  = sbac_pkg::CountW;

  logic [SlotW-1:0]  slot_limit;
  logic [ByteW-1:0]  byte_cap;

  logic              closing_flag, closing_flag_next;
  logic [SlotW-1:0]  slot_count, slot_count_next;
  logic [ByteW-1:0]  byte_count, byte_count_next;
  logic [SlotW-1:0]  slot_high_mark, slot_high_mark_next;
  logic [ByteW-1:0]  byte_high_mark, byte_high_mark_next;
  logic [CountW-1:0] slot_reject_count, slot_reject_count_next;
  logic [CountW-1:0] budget_reject_count, budget_reject_count_next;

  sbac_pkg::result_t result, out_reg, skid_reg;
  logic              out_valid, skid_valid;

  sbac_pkg::kind_t           kind;
  logic [sbac_pkg::SizeW-1:0] content_bytes;
  logic [sbac_pkg::GenW-1:0]  generation;
  logic [ByteW-1:0]           release_bytes;
  logic                       holds_slot;

  logic [ChargeW-1:0] charge;
  logic [ByteW:0]     byte_sum;
  logic               over_budget;
  logic               accept;

  assign kind          = sbac_pkg::kind_t'(s_tuser);
  assign content_bytes = s_tdata[39:0];
  assign generation    = s_tdata[71:40];
  assign release_bytes = s_tdata[119:72];
  assign holds_slot    = s_tdata[120];

  assign charge      = sbac_pkg::FixedCharge + {1'b0, content_bytes, 3'b000};
  assign byte_sum    = {1'b0, byte_count} + (ByteW+1)'(charge);
  assign over_budget = byte_sum > {1'b0, byte_cap};

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_reg;

  always_comb begin
    closing_flag_next        = closing_flag;
    slot_count_next          = slot_count;
    byte_count_next          = byte_count;
    slot_high_mark_next      = slot_high_mark;
    byte_high_mark_next      = byte_high_mark;
    slot_reject_count_next   = slot_reject_count;
    budget_reject_count_next = budget_reject_count;
    result.status            = sbac_pkg::ST_OK;
    result.charged_bytes     = '0;

    case (kind)
      sbac_pkg::KIND_RESERVE: begin
        if (content_bytes == '0 || generation == '0) begin
          result.status = sbac_pkg::ST_INVALID;
        end else if (closing_flag) begin
          result.status = sbac_pkg::ST_CLOSING;
        end else if (slot_count >= slot_limit) begin
          result.status          = sbac_pkg::ST_SLOTS;
          slot_reject_count_next = sbac_pkg::sat_inc(slot_reject_count);
        end else if (over_budget) begin
          result.status            = sbac_pkg::ST_BUDGET;
          budget_reject_count_next = sbac_pkg::sat_inc(budget_reject_count);
        end else begin
          slot_count_next      = slot_count + SlotW'(1);
          byte_count_next      = byte_sum[ByteW-1:0];
          result.charged_bytes = charge;
          if (slot_count_next > slot_high_mark) begin
            slot_high_mark_next = slot_count_next;
          end
          if (byte_count_next > byte_high_mark) begin
            byte_high_mark_next = byte_count_next;
          end
        end
      end
      sbac_pkg::KIND_PREPARED: begin
        if (slot_count == '0) begin
          result.status = sbac_pkg::ST_UNDERFLOW;
        end else begin
          slot_count_next = slot_count - SlotW'(1);
        end
      end
      sbac_pkg::KIND_RELEASE: begin
        if ((holds_slot && slot_count == '0) || byte_count < release_bytes) begin
          result.status = sbac_pkg::ST_UNDERFLOW;
        end else begin
          if (holds_slot) begin
            slot_count_next = slot_count - SlotW'(1);
          end
          byte_count_next = byte_count - release_bytes;
        end
      end
      default: begin
        closing_flag_next = 1'b1;
      end
    endcase

    result.is_closing        = closing_flag_next;
    result.budget_rejects    = budget_reject_count_next;
    result.slot_rejects      = slot_reject_count_next;
    result.byte_peak         = byte_high_mark_next;
    result.slot_peak         = slot_high_mark_next;
    result.active_byte_total = byte_count_next;
    result.active_slots      = slot_count_next;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_limit <= sbac_pkg::SlotLimitReset;
      byte_cap   <= sbac_pkg::ByteCapReset;
    end else if (cfg_we) begin
      case (sbac_pkg::reg_index_t'(cfg_index))
        sbac_pkg::REG_SLOT_LIMIT: slot_limit <= cfg_data[SlotW-1:0];
        sbac_pkg::REG_BYTE_CAP:   byte_cap   <= cfg_data;
        default: ;
      endcase
    end
  end

  // admission state
  always_ff @(posedge clk) begin
    if (rst) begin
      closing_flag        <= 1'b0;
      slot_count          <= '0;
      byte_count          <= '0;
      slot_high_mark      <= '0;
      byte_high_mark      <= '0;
      slot_reject_count   <= '0;
      budget_reject_count <= '0;
    end else if (accept) begin
      closing_flag        <= closing_flag_next;
      slot_count          <= slot_count_next;
      byte_count          <= byte_count_next;
      slot_high_mark      <= slot_high_mark_next;
      byte_high_mark      <= byte_high_mark_next;
      slot_reject_count   <= slot_reject_count_next;
      budget_reject_count <= budget_reject_count_next;
    end
  end

  // result register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      // skid is empty whenever an item is taken
      if (!out_valid || m_tready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (m_tready) begin
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!out_valid || m_tready) begin
        out_reg <= result;
      end else begin
        skid_reg <= result;
      end
    end else if (m_tready && skid_valid) begin
      out_reg <= skid_reg;
    end
  end

endmodule

// ----- sim/testbench.sv -----
// testbench for slot_and_byte_admission_control: random and directed requests, scoreboard
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned ByteW      = sbac_pkg::ByteW;
  localparam int unsigned InDataW    = sbac_pkg::InDataW;
  localparam int unsigned OutDataW   = sbac_pkg::OutDataW;
  localparam int unsigned CycleLimit = 400000;
  localparam logic [63:0] ChargeBase = 64'd16777216;

  typedef struct packed {
    sbac_pkg::kind_t kind;
    logic [39:0]     content_bytes;
    logic [31:0]     generation;
    logic [47:0]     release_bytes;
    logic            holds_slot;
  } request_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic                cfg_index = 1'b0;
  logic [ByteW-1:0]    cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic [1:0]          s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;

  slot_and_byte_admission_control DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state and its copy of the registers
  logic [15:0] slot_limit_cfg = 16'd16;
  logic [47:0] byte_cap_cfg = '0;
  logic        admission_closed = 1'b0;
  logic [15:0] slots_held = '0;
  logic [47:0] bytes_held = '0;
  logic [15:0] slot_high = '0;
  logic [47:0] byte_high = '0;
  logic [31:0] slot_reject_tally = '0;
  logic [31:0] budget_reject_tally = '0;

  request_t          pending_requests[$];
  sbac_pkg::result_t expected_results[$];
  request_t          drive_req;
  sbac_pkg::result_t predicted;
  sbac_pkg::result_t observed;
  sbac_pkg::result_t wanted;
  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 88;
  int unsigned mismatches = 0;
  int unsigned requests_sent = 0;
  int unsigned results_checked = 0;
  int unsigned status_tally[6] = '{default: 0};
  int unsigned cycle_count = 0;

  function automatic sbac_pkg::result_t account_request(input request_t req);
    sbac_pkg::result_t res;
    logic [63:0]       charge;
    res = '0;
    res.status = sbac_pkg::ST_OK;
    case (req.kind)
      sbac_pkg::KIND_RESERVE: begin
        // payload check wins over closing and both limits
        if (req.content_bytes == '0 || req.generation == '0) begin
          res.status = sbac_pkg::ST_INVALID;
        end else if (admission_closed) begin
          res.status = sbac_pkg::ST_CLOSING;
        end else if (slots_held >= slot_limit_cfg) begin
          res.status = sbac_pkg::ST_SLOTS;
          if (slot_reject_tally != '1) slot_reject_tally = slot_reject_tally + 32'd1;
        end else begin
          charge = ChargeBase + ({24'b0, req.content_bytes} << 3);
          if ({16'b0, bytes_held} + charge > {16'b0, byte_cap_cfg}) begin
            res.status = sbac_pkg::ST_BUDGET;
            if (budget_reject_tally != '1) begin
              budget_reject_tally = budget_reject_tally + 32'd1;
            end
          end else begin
            slots_held = slots_held + 16'd1;
            bytes_held = bytes_held + charge[47:0];
            if (slots_held > slot_high) slot_high = slots_held;
            if (bytes_held > byte_high) byte_high = bytes_held;
            res.charged_bytes = charge[43:0];
          end
        end
      end
      sbac_pkg::KIND_PREPARED: begin
        if (slots_held == '0) res.status = sbac_pkg::ST_UNDERFLOW;
        else slots_held = slots_held - 16'd1;
      end
      sbac_pkg::KIND_RELEASE: begin
        if ((req.holds_slot && slots_held == '0) || bytes_held < req.release_bytes) begin
          res.status = sbac_pkg::ST_UNDERFLOW;
        end else begin
          if (req.holds_slot) slots_held = slots_held - 16'd1;
          bytes_held = bytes_held - req.release_bytes;
        end
      end
      default: admission_closed = 1'b1;
    endcase
    res.active_slots      = slots_held;
    res.active_byte_total = bytes_held;
    res.slot_peak         = slot_high;
    res.byte_peak         = byte_high;
    res.slot_rejects      = slot_reject_tally;
    res.budget_rejects    = budget_reject_tally;
    res.is_closing        = admission_closed;
    return res;
  endfunction

  task automatic check_field(input string field, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
      mismatches++;
    end
  endtask

  // driver: holds an item until it is taken, idles between items at random
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predicted = account_request(drive_req);
        expected_results = {expected_results, predicted};
        status_tally[predicted.status]++;
        requests_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drive_req = pending_requests.pop_front();
          s_tdata  <= {7'b0, drive_req.holds_slot, drive_req.release_bytes,
                       drive_req.generation, drive_req.content_bytes};
          s_tuser  <= drive_req.kind;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, each result checked against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        observed = sbac_pkg::result_t'(m_tdata);
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, m_tdata);
          mismatches++;
        end else begin
          wanted = expected_results.pop_front();
          results_checked++;
          check_field("status", wanted.status, observed.status);
          check_field("charged_bytes", wanted.charged_bytes, observed.charged_bytes);
          check_field("active_slots", wanted.active_slots, observed.active_slots);
          check_field("active_byte_total", wanted.active_byte_total,
                      observed.active_byte_total);
          check_field("slot_peak", wanted.slot_peak, observed.slot_peak);
          check_field("byte_peak", wanted.byte_peak, observed.byte_peak);
          check_field("slot_rejects", wanted.slot_rejects, observed.slot_rejects);
          check_field("budget_rejects", wanted.budget_rejects, observed.budget_rejects);
          check_field("is_closing", wanted.is_closing, observed.is_closing);
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [39:0] rand40();
    return {8'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic push_request(input sbac_pkg::kind_t kind, input logic [39:0] size,
                              input logic [31:0] gen, input logic [47:0] rel,
                              input logic holds);
    request_t r;
    r.kind          = kind;
    r.content_bytes = size;
    r.generation    = gen;
    r.release_bytes = rel;
    r.holds_slot    = holds;
    pending_requests = {pending_requests, r};
  endtask

  // pause the sender until every item has come back
  task automatic wait_drained();
    do @(posedge clk);
    while (!(pending_requests.size() == 0 && !s_tvalid && expected_results.size() == 0));
  endtask

  task automatic write_reg(input sbac_pkg::reg_index_t idx, input logic [47:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sbac_pkg::REG_SLOT_LIMIT) slot_limit_cfg = value[15:0];
    else byte_cap_cfg = value;
  endtask

  // mostly well-formed traffic sized from the predicted state, the rest noise
  task automatic queue_random(input int unsigned count, input bit allow_close);
    request_t    r;
    int unsigned pick;
    int unsigned sel;
    logic [63:0] span;
    for (int n = 0; n < count; n++) begin
      while (pending_requests.size() >= 2) @(posedge clk);
      r.kind          = sbac_pkg::KIND_RESERVE;
      r.content_bytes = rand40();
      r.generation    = $urandom;
      r.release_bytes = rand48();
      r.holds_slot    = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        r.kind = sbac_pkg::kind_t'(allow_close ? $urandom_range(0, 3)
                                               : $urandom_range(0, 2));
      end else if (pick < 55) begin
        sel = $urandom_range(0, 19);
        if (sel == 0) r.content_bytes = '0;
        else if (sel > 3) r.content_bytes = 40'($urandom_range(1, 1 << 22));
        if ($urandom_range(0, 19) == 0) r.generation = '0;
        else if (r.generation == '0) r.generation = 32'd1;
      end else if (pick < 70) begin
        r.kind = sbac_pkg::KIND_PREPARED;
      end else if (pick < 96 || !allow_close) begin
        r.kind = sbac_pkg::KIND_RELEASE;
        r.holds_slot = (slots_held != '0) && ($urandom_range(0, 2) != 0);
        span = {16'b0, bytes_held};
        if ($urandom_range(0, 4) == 0) r.release_bytes = span[47:0];
        else r.release_bytes = 48'({$urandom, $urandom} % (span + 1));
      end else begin
        r.kind = sbac_pkg::KIND_CLOSE;
      end
      pending_requests = {pending_requests, r};
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings: no budget, so every well-formed reserve is refused
    send_idle_pct = 35;
    recv_idle_pct = 88;
    push_request(sbac_pkg::KIND_RESERVE, 40'd1, 32'd1, '0, 1'b0);
    push_request(sbac_pkg::KIND_RESERVE, 40'd0, 32'd5, '1, 1'b1);
    push_request(sbac_pkg::KIND_RESERVE, 40'd5, 32'd0, '0, 1'b0);
    push_request(sbac_pkg::KIND_PREPARED, '1, '1, '1, 1'b1);
    push_request(sbac_pkg::KIND_RELEASE, '0, '0, 48'd0, 1'b1);
    push_request(sbac_pkg::KIND_RELEASE, '0, '0, 48'd1, 1'b0);
    push_request(sbac_pkg::KIND_RELEASE, '1, '1, 48'd0, 1'b0);
    wait_drained();

    write_reg(sbac_pkg::REG_SLOT_LIMIT, 48'd2);
    write_reg(sbac_pkg::REG_BYTE_CAP, '1);
    push_request(sbac_pkg::KIND_RESERVE, '1, '1, '0, 1'b0);
    push_request(sbac_pkg::KIND_RESERVE, 40'd1, 32'd1, '0, 1'b0);
    push_request(sbac_pkg::KIND_RESERVE, 40'd1, 32'd1, '0, 1'b0);
    push_request(sbac_pkg::KIND_PREPARED, '0, '0, '0, 1'b0);
    push_request(sbac_pkg::KIND_RESERVE, 40'd7, 32'd3, '0, 1'b0);
    push_request(sbac_pkg::KIND_RELEASE, '0, '0, '1, 1'b1);
    push_request(sbac_pkg::KIND_RELEASE, '0, '0, 48'd16777224, 1'b1);
    push_request(sbac_pkg::KIND_RELEASE, '0, '0, 48'd16777272, 1'b1);
    push_request(sbac_pkg::KIND_RELEASE, '0, '0, 48'd8796109799416, 1'b0);
    push_request(sbac_pkg::KIND_PREPARED, '0, '0, '0, 1'b0);
    wait_drained();

    // budget exactly one smallest charge: the first fits, the next overruns
    write_reg(sbac_pkg::REG_BYTE_CAP, 48'd16777224);
    push_request(sbac_pkg::KIND_RESERVE, 40'd1, 32'd9, '0, 1'b0);
    push_request(sbac_pkg::KIND_RESERVE, 40'd1, 32'd9, '0, 1'b0);
    push_request(sbac_pkg::KIND_RELEASE, '0, '0, 48'd16777224, 1'b1);
    wait_drained();

    write_reg(sbac_pkg::REG_SLOT_LIMIT, 48'hFFFF);
    write_reg(sbac_pkg::REG_BYTE_CAP, '1);
    queue_random(230, 1'b0);
    wait_drained();

    send_idle_pct = 88;
    recv_idle_pct = 35;
    write_reg(sbac_pkg::REG_SLOT_LIMIT, 48'd0);
    queue_random(25, 1'b0);
    wait_drained();

    write_reg(sbac_pkg::REG_SLOT_LIMIT, 48'd5);
    write_reg(sbac_pkg::REG_BYTE_CAP, 48'd300000000);
    queue_random(230, 1'b0);
    wait_drained();

    // empty out, hold three slots, then lower the limit under them
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_request(sbac_pkg::KIND_RELEASE, '0, '0, bytes_held, 1'b0);
    repeat (slots_held) push_request(sbac_pkg::KIND_PREPARED, '0, '0, '0, 1'b0);
    repeat (3) push_request(sbac_pkg::KIND_RESERVE, 40'd1, 32'd2, '0, 1'b0);
    wait_drained();
    write_reg(sbac_pkg::REG_SLOT_LIMIT, 48'd1);
    push_request(sbac_pkg::KIND_RESERVE, 40'd4, 32'd4, '0, 1'b0);
    push_request(sbac_pkg::KIND_PREPARED, '0, '0, '0, 1'b0);
    push_request(sbac_pkg::KIND_PREPARED, '0, '0, '0, 1'b0);
    push_request(sbac_pkg::KIND_RESERVE, 40'd4, 32'd4, '0, 1'b0);
    push_request(sbac_pkg::KIND_PREPARED, '0, '0, '0, 1'b0);
    push_request(sbac_pkg::KIND_RESERVE, 40'd4, 32'd4, '0, 1'b0);
    wait_drained();

    write_reg(sbac_pkg::REG_SLOT_LIMIT, 48'd4);
    write_reg(sbac_pkg::REG_BYTE_CAP, 48'd250000000);
    queue_random(180, 1'b0);
    // closing is permanent, so it comes last
    push_request(sbac_pkg::KIND_CLOSE, '0, '0, '0, 1'b0);
    push_request(sbac_pkg::KIND_CLOSE, '1, '1, '1, 1'b1);
    queue_random(40, 1'b1);
    wait_drained();
    repeat (5) @(posedge clk);

    $display("covered %0d items over three idling patterns: ok %0d, invalid %0d,",
             requests_sent, status_tally[sbac_pkg::ST_OK],
             status_tally[sbac_pkg::ST_INVALID]);
    $display("closing %0d, slots full %0d, budget %0d, underflow %0d; %0d results checked",
             status_tally[sbac_pkg::ST_CLOSING], status_tally[sbac_pkg::ST_SLOTS],
             status_tally[sbac_pkg::ST_BUDGET], status_tally[sbac_pkg::ST_UNDERFLOW],
             results_checked);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
